@@ hw/rtl/fcpf_pkg.sv @@
// Shared types and constants for the framebuffer changed-pixel finder.
package fcpf_pkg;

	localparam int unsigned DEF_FRAME_BYTES        = 1024;
	localparam int unsigned DEF_NARROW_FRAME_BYTES = 256;
	localparam int unsigned DEF_WIDE_WIDTH         = 128;
	localparam int unsigned DEF_NARROW_WIDTH       = 64;

	localparam int unsigned IDX_W   = 10;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned X_W     = 7;
	localparam int unsigned Y_W     = 6;
	localparam int unsigned SIZE_W  = 2;

	localparam int unsigned PIX_W     = IDX_W + 3;
	localparam int unsigned DIV_SHIFT = 24;
	localparam int unsigned RECIP_W   = 22;
	localparam int unsigned PROD_W    = PIX_W + RECIP_W;
	localparam int unsigned ROW_W     = 10;
	localparam int unsigned GRID_W    = 9;
	localparam int unsigned COL_W     = 8;
	localparam int unsigned QW_W      = ROW_W + GRID_W;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_EXT_MODE_ADDR = 3'd0;

	typedef enum logic {
		OP_COMPARE = 1'b0,
		OP_CLEAR   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_EMIT
	} st_t;

endpackage

@@ hw/rtl/framebuffer_changed_pixel_finder_top.sv @@
// Top level of the framebuffer changed-pixel finder.
//
// Input channel (in_valid/in_stall) takes one item: op, byte_index, new_byte.
// A compare item reads the stored byte, and for each changed bit, MSB first,
// one result goes out on the output channel (out_valid/out_stall) with render
// coordinates, lit, pixel_size and last. The stored byte is replaced before the first result.
// A clear item zeroes the store and gives no result.
// Steps per item, from accept to the next accept:
//   n changed pixels (1..8): the registered shown-frame RAM read, the coordinate
//   divide step (ST_DIV) and the remainder step (ST_REM) come before the first
//   result is registered, then one per cycle while the receiver does not stall.
//   unchanged byte: the RAM read and ST_DIV only; index outside the active frame:
//   the block stays idle. clear: all FRAME_BYTES entries, one RAM entry zeroed per cycle.
// After reset the same clearing pass runs over all FRAME_BYTES entries with in_stall
// high; configuration writes are taken at any time.
// A stalled receiver holds the output register and the emitter waits; the next
// item is accepted while the final result of an item still waits to be taken.
module framebuffer_changed_pixel_finder_top
	import fcpf_pkg::*;
#(
	parameter int unsigned FRAME_BYTES        = DEF_FRAME_BYTES,
	parameter int unsigned NARROW_FRAME_BYTES = DEF_NARROW_FRAME_BYTES,
	parameter int unsigned WIDE_WIDTH         = DEF_WIDE_WIDTH,
	parameter int unsigned NARROW_WIDTH       = DEF_NARROW_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [IDX_W-1:0]   byte_index,
	input  logic [BYTE_W-1:0]  new_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [X_W-1:0]     x_pos,
	output logic [Y_W-1:0]     y_pos,
	output logic               lit,
	output logic [SIZE_W-1:0]  pixel_size,
	output logic               last
);

	localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(FRAME_BYTES - 1);
	localparam int unsigned WIDE_RECIP =
		((32'd1 << DIV_SHIFT) + WIDE_WIDTH - 1) / WIDE_WIDTH;
	localparam int unsigned NARROW_RECIP =
		((32'd1 << DIV_SHIFT) + NARROW_WIDTH - 1) / NARROW_WIDTH;

	st_t state_q, state_d;

	logic                  ext_mode_q;
	logic [ADDR_W-1:0]     clr_cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [BYTE_W-1:0]     nb_q;
	logic [BYTE_W-1:0]     diff_q;
	logic [ROW_W-1:0]      row_q;
	logic [COL_W-1:0]      col_q;

	logic                  out_valid_q;
	logic [X_W-1:0]        x_pos_q;
	logic [Y_W-1:0]        y_pos_q;
	logic                  lit_q;
	logic [SIZE_W-1:0]     pixel_size_q;
	logic                  last_q;

	logic                  accept;
	logic                  in_range;
	logic [31:0]           idx_in_ext;
	logic [31:0]           idx_q_ext;
	logic [31:0]           active_bytes;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [BYTE_W-1:0]     ram_wdata;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [BYTE_W-1:0]     ram_rdata;

	logic [PIX_W-1:0]      pix_base;
	logic [RECIP_W-1:0]    recip_sel;
	logic [GRID_W-1:0]     grid_w;
	logic [PROD_W-1:0]     prod;
	logic [QW_W-1:0]       qw;
	logic [PIX_W-1:0]      rem_full;
	logic [BYTE_W-1:0]     diff_rd;

	logic [2:0]            bit_pos;
	logic                  found;
	logic [GRID_W-1:0]     col_sum;
	logic                  col_wrap;
	logic [GRID_W-1:0]     col_adj;
	logic [ROW_W-1:0]      row_cur;
	logic [BYTE_W-1:0]     diff_next;
	logic                  load_out;
	logic                  cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == REG_EXT_MODE_ADDR) ? {{(PDATA_W-1){1'b0}}, ext_mode_q}
		: '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_mode_q <= 1'b0;
		end else if (cfg_wr && paddr == REG_EXT_MODE_ADDR) begin
			ext_mode_q <= pwdata[0];
		end
	end

	// input decode
	assign idx_in_ext   = 32'(byte_index);
	assign idx_q_ext    = 32'(idx_q);
	assign active_bytes = ext_mode_q ? 32'(FRAME_BYTES) : 32'(NARROW_FRAME_BYTES);
	assign in_range     = (idx_in_ext < active_bytes) && (idx_in_ext < 32'(FRAME_BYTES));
	assign accept       = in_valid && !in_stall;
	assign ram_raddr    = idx_in_ext[ADDR_W-1:0];

	// coordinate math: row = pixel / width by reciprocal, col = remainder
	assign pix_base  = {idx_q, 3'b000};
	assign recip_sel = ext_mode_q ? RECIP_W'(WIDE_RECIP) : RECIP_W'(NARROW_RECIP);
	assign grid_w    = ext_mode_q ? GRID_W'(WIDE_WIDTH) : GRID_W'(NARROW_WIDTH);
	assign prod      = PROD_W'(pix_base) * PROD_W'(recip_sel);
	assign qw        = QW_W'(row_q) * QW_W'(grid_w);
	assign rem_full  = pix_base - qw[PIX_W-1:0];
	assign diff_rd   = ram_rdata ^ nb_q;

	// next changed bit, MSB first
	always_comb begin
		bit_pos = 3'd0;
		found   = 1'b0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (!found && diff_q[BYTE_W-1-i]) begin
				bit_pos = 3'(i);
				found   = 1'b1;
			end
		end
	end

	assign col_sum   = GRID_W'(col_q) + GRID_W'(bit_pos);
	assign col_wrap  = (col_sum >= grid_w);
	assign col_adj   = col_wrap ? (col_sum - grid_w) : col_sum;
	assign row_cur   = row_q + ROW_W'(col_wrap);
	assign diff_next = diff_q & ~(8'h80 >> bit_pos);
	assign load_out  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= (clr_cnt_q == CLR_LAST) ? '0 : clr_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = idx_q_ext[ADDR_W-1:0];
		ram_wdata = nb_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
				if (clr_cnt_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (op == OP_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (in_range) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				ram_we  = 1'b1;
				state_d = (diff_rd == '0) ? ST_IDLE : ST_REM;
			end
			ST_REM: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_out && diff_next == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= byte_index;
			nb_q  <= new_byte;
		end
		if (state_q == ST_DIV) begin
			diff_q <= diff_rd;
			row_q  <= prod[DIV_SHIFT+ROW_W-1:DIV_SHIFT];
		end
		if (state_q == ST_REM) begin
			col_q <= rem_full[COL_W-1:0];
		end
		if (load_out) begin
			diff_q <= diff_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			x_pos_q      <= ext_mode_q ? col_adj[X_W-1:0] : {col_adj[X_W-2:0], 1'b0};
			y_pos_q      <= ext_mode_q ? row_cur[Y_W-1:0] : {row_cur[Y_W-2:0], 1'b0};
			lit_q        <= nb_q[BYTE_W-1-bit_pos];
			pixel_size_q <= ext_mode_q ? SIZE_W'(1) : SIZE_W'(2);
			last_q       <= (diff_next == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign x_pos      = x_pos_q;
	assign y_pos      = y_pos_q;
	assign lit        = lit_q;
	assign pixel_size = pixel_size_q;
	assign last       = last_q;

	fcpf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FRAME_BYTES)
	) u_shown_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef SYNTH
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_CLEAR || in_range)) |=> in_stall)
		else $error("item accepted on back-to-back cycles");

	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (diff_q != '0))
		else $error("emitter active with no changed pixel left");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && diff_next == '0) |=> (state_q == ST_IDLE && last_q))
		else $error("final result did not end the item");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_cnt_q == CLR_LAST) |=>
			(state_q == ST_IDLE && clr_cnt_q == '0))
		else $error("clearing pass did not finish on the last entry");
`endif

endmodule

@@ hw/rtl/fcpf_ram.sv @@
// Generic simple dual-port RAM with registered read.
module fcpf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ test/tb_framebuffer_changed_pixel_finder_top.sv @@
// Testbench for the framebuffer changed-pixel finder: predicts each pixel item and checks it.
`timescale 1ns / 1ps

module tb_framebuffer_changed_pixel_finder_top;
	import fcpf_pkg::*;

	typedef struct packed {
		logic [X_W-1:0]    x_pos;
		logic [Y_W-1:0]    y_pos;
		logic              lit;
		logic [SIZE_W-1:0] pixel_size;
		logic              last;
	} pixel_t;

	localparam int unsigned CLEAR_WAIT = DEF_FRAME_BYTES + 80;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic               op;
	logic [IDX_W-1:0]   byte_index;
	logic [BYTE_W-1:0]  new_byte;
	logic               out_valid;
	logic               out_stall;
	logic [X_W-1:0]     x_pos;
	logic [Y_W-1:0]     y_pos;
	logic               lit;
	logic [SIZE_W-1:0]  pixel_size;
	logic               last;

	logic [BYTE_W-1:0] shown_copy [DEF_FRAME_BYTES];
	logic              wide_grid;
	pixel_t            pending_pixels [$];
	int unsigned       mismatches;
	bit                pace_on;
	int unsigned       burst_left;
	int unsigned       hold_left;

	framebuffer_changed_pixel_finder_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .byte_index(byte_index), .new_byte(new_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_pos(x_pos), .y_pos(y_pos), .lit(lit), .pixel_size(pixel_size), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Expected pixel items for one accepted item; updates the shadow frame.
	function automatic void predict_changed_pixels(op_t o, logic [IDX_W-1:0] idx,
			logic [BYTE_W-1:0] nb);
		int unsigned active;
		int unsigned width;
		int unsigned scale;
		int unsigned pix;
		logic [BYTE_W-1:0] diff;
		pixel_t p;
		if (o == OP_CLEAR) begin
			foreach (shown_copy[i]) shown_copy[i] = '0;
			return;
		end
		active = wide_grid ? DEF_FRAME_BYTES : DEF_NARROW_FRAME_BYTES;
		width = wide_grid ? DEF_WIDE_WIDTH : DEF_NARROW_WIDTH;
		scale = wide_grid ? 1 : 2;
		if (idx >= active) return;
		diff = shown_copy[idx] ^ nb;
		if (diff == '0) return;
		for (int b = 0; b < 8; b++) begin
			if (diff[7-b]) begin
				pix = idx * 8 + b;
				p.x_pos = X_W'((pix % width) * scale);
				p.y_pos = Y_W'((pix / width) * scale);
				p.lit = nb[7-b];
				p.pixel_size = SIZE_W'(scale);
				p.last = 1'b0;
				pending_pixels.push_back(p);
			end
		end
		pending_pixels[pending_pixels.size()-1].last = 1'b1;
		shown_copy[idx] = nb;
	endfunction

	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel x=%0d y=%0d", x_pos, y_pos));
			end else begin
				e = pending_pixels.pop_front();
				if (x_pos !== e.x_pos)
					report_mismatch($sformatf("x_pos %0d, want %0d", x_pos, e.x_pos));
				if (y_pos !== e.y_pos)
					report_mismatch($sformatf("y_pos %0d, want %0d", y_pos, e.y_pos));
				if (lit !== e.lit)
					report_mismatch($sformatf("lit %0b, want %0b", lit, e.lit));
				if (pixel_size !== e.pixel_size)
					report_mismatch($sformatf("pixel_size %0d, want %0d",
						pixel_size, e.pixel_size));
				if (last !== e.last)
					report_mismatch($sformatf("last %0b, want %0b", last, e.last));
			end
		end
	end

	// Receiver: long hold when requested, else one of four stall patterns, picked again at random.
	initial begin
		int unsigned mode;
		int unsigned cnt;
		mode = 0;
		cnt = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			cnt++;
			if (cnt % 64 == 0) mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 3) == 0);
					2: out_stall = ($urandom_range(0, 9) < 6);
					default: out_stall = (cnt % 4 == 0);
				endcase
			end
		end
	end

	task automatic send_item(input op_t o, input logic [IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] nb);
		if (pace_on && burst_left == 0) begin
			repeat ($urandom_range(1, 6)) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		op = o;
		byte_index = idx;
		new_byte = nb;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_changed_pixels(o, idx, nb);
		if (burst_left > 0) burst_left--;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_for_pixels();
		int unsigned n;
		n = 0;
		while (pending_pixels.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
	endtask

	// Register write, only with the block idle (it first waits out a clear that may still be running).
	task automatic set_grid_mode(input logic wide);
		stop_sending();
		wait_for_pixels();
		repeat (CLEAR_WAIT) @(posedge clk);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = REG_EXT_MODE_ADDR;
		pwdata = {{(PDATA_W-1){1'b0}}, wide};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		wide_grid = wide;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic test_narrow_directed();
		pace_on = 1'b1;
		set_grid_mode(1'b0);
		send_item(OP_COMPARE, 10'd0, 8'hFF);
		send_item(OP_COMPARE, 10'd0, 8'hFF);
		send_item(OP_COMPARE, 10'd0, 8'h00);
		send_item(OP_COMPARE, 10'd255, 8'h81);
		send_item(OP_COMPARE, 10'd256, 8'hFF);
		send_item(OP_COMPARE, 10'd1023, 8'hFF);
		send_item(OP_COMPARE, 10'd7, 8'hAA);
		send_item(OP_COMPARE, 10'd8, 8'h55);
		send_item(OP_CLEAR, 10'h3FF, 8'hFF);
		send_item(OP_COMPARE, 10'd255, 8'h00);
		send_item(OP_COMPARE, 10'd255, 8'h01);
		stop_sending();
	endtask

	task automatic test_wide_directed();
		set_grid_mode(1'b1);
		send_item(OP_COMPARE, 10'd1023, 8'hFF);
		send_item(OP_COMPARE, 10'd1023, 8'h00);
		send_item(OP_COMPARE, 10'h2AA, 8'h55);
		send_item(OP_COMPARE, 10'h155, 8'hAA);
		send_item(OP_COMPARE, 10'd255, 8'h01);
		send_item(OP_COMPARE, 10'd256, 8'h80);
		send_item(OP_COMPARE, 10'd0, 8'hFF);
		send_item(OP_COMPARE, 10'd15, 8'h80);
		send_item(OP_COMPARE, 10'd16, 8'h01);
		stop_sending();
	endtask

	task automatic send_random_items(input int unsigned count);
		int unsigned r;
		int unsigned top;
		logic [IDX_W-1:0] idx;
		logic [BYTE_W-1:0] nb;
		for (int unsigned i = 0; i < count; i++) begin
			top = wide_grid ? DEF_FRAME_BYTES - 1 : DEF_NARROW_FRAME_BYTES - 1;
			r = $urandom_range(0, 99);
			idx = IDX_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
				: $urandom_range(0, top));
			nb = BYTE_W'($urandom_range(0, 255));
			if (r < 2) begin
				send_item(OP_CLEAR, IDX_W'($urandom_range(0, 1023)), nb);
			end else if (r < 17) begin
				send_item(OP_COMPARE, idx, shown_copy[idx]);
			end else if (r < 30) begin
				send_item(OP_COMPARE, idx, shown_copy[idx] ^ (8'h80 >> $urandom_range(0, 7)));
			end else if (r < 38 && !wide_grid) begin
				send_item(OP_COMPARE, IDX_W'($urandom_range(DEF_NARROW_FRAME_BYTES, 1023)),
					nb);
			end else begin
				send_item(OP_COMPARE, idx, nb);
			end
		end
		stop_sending();
	endtask

	task automatic test_random_phases();
		set_grid_mode(1'b0);
		send_random_items(110);
		set_grid_mode(1'b1);
		pace_on = 1'b0;
		send_random_items(60);
		pace_on = 1'b1;
		send_random_items(60);
		set_grid_mode(1'b0);
		send_random_items(70);
		set_grid_mode(1'b1);
		send_random_items(70);
	endtask

	task automatic test_receiver_hold();
		pace_on = 1'b0;
		hold_left = 300;
		for (int i = 0; i < 12; i++)
			send_item(OP_COMPARE, IDX_W'($urandom_range(0, 1023)),
				BYTE_W'($urandom_range(0, 255)));
		stop_sending();
		pace_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		send_random_items(15);
		wait_for_pixels();
		send_random_items(15);
	endtask

	initial begin
		foreach (shown_copy[i]) shown_copy[i] = '0;
		wide_grid = 1'b0;
		mismatches = 0;
		pace_on = 1'b1;
		burst_left = 0;
		hold_left = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		op = OP_COMPARE;
		byte_index = '0;
		new_byte = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_narrow_directed();
		test_wide_directed();
		test_random_phases();
		test_receiver_hold();
		test_sender_pause();

		wait_for_pixels();
		repeat (20) @(posedge clk);
		if (pending_pixels.size() != 0)
			report_mismatch($sformatf("%0d pixel items never came", pending_pixels.size()));
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ framebuffer_changed_pixel_finder_top.f @@
hw/rtl/fcpf_pkg.sv
hw/rtl/fcpf_ram.sv
hw/rtl/framebuffer_changed_pixel_finder_top.sv
test/tb_framebuffer_changed_pixel_finder_top.sv
